// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with reset disable, included by the tracker unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vsmppt_pkg.sv =====
// ----------------------------------------------------------------------------
// vsmppt_pkg
// Widths, register codes, sequencer states and control bundles of the tracker.
// ----------------------------------------------------------------------------
package vsmppt_pkg;

    localparam int VOLT_BITS   = 16;
    localparam int CUR_BITS    = 16;
    localparam int REG_W       = 16;
    localparam int SCALE_SHIFT = 16;

    localparam int PW     = VOLT_BITS + CUR_BITS;
    localparam int MB     = (CUR_BITS > REG_W) ? CUR_BITS : REG_W;
    localparam int NW     = PW + MB;
    localparam int QS_W   = NW - SCALE_SHIFT;
    localparam int CNT_W  = $clog2(NW + 1);
    localparam int RW     = ((VOLT_BITS > REG_W) ? VOLT_BITS : REG_W) + 1;
    localparam int IN_W   = ((CUR_BITS + VOLT_BITS + 7) / 8) * 8;
    localparam int OUT_W  = ((VOLT_BITS + 7) / 8) * 8;
    localparam int CIDX_W = 4;

    localparam logic [REG_W-1:0] RST_SLOPE_GAIN    = 16'd66;
    localparam logic [REG_W-1:0] RST_MAX_STEP      = 16'd200;
    localparam logic [REG_W-1:0] RST_MIN_STEP      = 16'd10;
    localparam logic [REG_W-1:0] RST_START_VOLTAGE = 16'd10000;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SLOPE_GAIN    = 4'd0,
        CFG_MAX_STEP      = 4'd1,
        CFG_MIN_STEP      = 4'd2,
        CFG_START_VOLTAGE = 4'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PWR,
        S_DIFF,
        S_GAIN,
        S_DIVST,
        S_DIV,
        S_CLAMP,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic en;
        logic sel_gain;
    } t_mul_ctl;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== rtl/core/variable_step_mppt_tracker_unit.sv =====
// Sequence: an accepted sample runs S_PWR, S_DIFF, S_GAIN, S_DIVST, S_DIV and
//   S_CLAMP to S_APPLY; with the panel voltage unchanged no division is run.
// Flow: input is not ready while the sequencer runs, so a new sample is taken
//   only once it is back in S_IDLE; S_APPLY waits while the output is stalled.
// Reset: synchronous active low; registers return to defaults, last sample to
//   zero, reference to the start voltage; no beat is taken while reset is held.
// ----------------------------------------------------------------------------
// variable_step_mppt_tracker_unit
// Variable-step perturb-and-observe tracker: one shared multiplier and a serial
// divider under a small sequencer produce the next voltage reference per sample.
// ----------------------------------------------------------------------------
module variable_step_mppt_tracker_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pv_current, pv_voltage
    input  logic [vsmppt_pkg::IN_W-1:0]          s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // voltage_reference
    output logic [vsmppt_pkg::OUT_W-1:0]         m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [vsmppt_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [vsmppt_pkg::REG_W-1:0]         i_cfg_data
);
    import vsmppt_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_mul_ctl mul_ctl;
    t_div_ctl div_ctl;
    t_div_sts div_sts;

    logic [REG_W-1:0]     r_gain;
    logic [REG_W-1:0]     r_max_step;
    logic [REG_W-1:0]     r_min_step;
    logic [VOLT_BITS-1:0] r_ref;
    logic [VOLT_BITS-1:0] r_last_volt;
    logic [PW-1:0]        r_last_power;

    logic [CUR_BITS-1:0]  r_cur;
    logic [VOLT_BITS-1:0] r_volt;
    logic [PW-1:0]        r_adp;
    logic [VOLT_BITS-1:0] r_adv;
    logic                 r_dp_pos;
    logic                 r_dp_neg;
    logic                 r_dv_pos;
    logic [REG_W-1:0]     r_step;
    logic                 r_out_valid;
    logic [VOLT_BITS-1:0] r_out_ref;

    logic [NW-1:0]        mul_prod;
    logic [NW-1:0]        div_quo;
    logic                 in_acc;
    logic                 cfg_acc;
    logic                 diff_en;
    logic                 step_min_en;
    logic                 clamp_en;
    logic                 apply_en;
    logic                 out_stall;
    logic [PW-1:0]        power;
    logic [QS_W-1:0]      qs;
    logic [REG_W-1:0]     step_hi;
    logic [REG_W-1:0]     step_clamped;
    logic [RW-1:0]        ref_e;
    logic [RW-1:0]        step_e;
    logic [RW-1:0]        vmax_e;
    logic [VOLT_BITS-1:0] ref_next;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = i_rst_n && (r_state == S_IDLE);

    vsmppt_mul u_mul (
        .i_clk  (i_clk),
        .i_ctl  (mul_ctl),
        .i_volt (r_volt),
        .i_cur  (r_cur),
        .i_adp  (r_adp),
        .i_gain (r_gain),
        .o_prod (mul_prod)
    );

    vsmppt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (mul_prod),
        .i_den   (r_adv),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_PWR;
            S_PWR:   n_state = S_DIFF;
            S_DIFF:  n_state = S_GAIN;
            S_GAIN:  n_state = S_DIVST;
            S_DIVST: n_state = (r_adv == '0) ? S_APPLY : S_DIV;
            S_DIV:   if (div_sts.done) n_state = S_CLAMP;
            S_CLAMP: n_state = S_APPLY;
            S_APPLY: if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready    = 1'b0;
        mul_ctl.en       = 1'b0;
        mul_ctl.sel_gain = 1'b0;
        div_ctl.start    = 1'b0;
        diff_en          = 1'b0;
        step_min_en      = 1'b0;
        clamp_en         = 1'b0;
        apply_en         = 1'b0;
        case (r_state)
            S_IDLE:  s_axis_tready = i_rst_n;
            S_PWR:   mul_ctl.en = 1'b1;
            S_DIFF:  diff_en = 1'b1;
            S_GAIN: begin
                mul_ctl.en       = 1'b1;
                mul_ctl.sel_gain = 1'b1;
            end
            S_DIVST: begin
                if (r_adv == '0) begin
                    step_min_en = 1'b1;
                end else begin
                    div_ctl.start = 1'b1;
                end
            end
            S_CLAMP: clamp_en = 1'b1;
            S_APPLY: apply_en = !r_out_valid || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign power = mul_prod[PW-1:0];
    assign qs    = div_quo[NW-1:SCALE_SHIFT];

    always_comb begin
        if (qs > QS_W'(r_max_step)) begin
            step_hi = r_max_step;
        end else begin
            step_hi = qs[REG_W-1:0];
        end
        step_clamped = (step_hi < r_min_step) ? r_min_step : step_hi;
    end

    always_comb begin
        ref_e    = RW'(r_ref);
        step_e   = RW'(r_step);
        vmax_e   = RW'({VOLT_BITS{1'b1}});
        ref_next = r_ref;
        if (r_dp_pos || r_dp_neg) begin
            if (r_dp_pos == r_dv_pos) begin
                if (step_e > vmax_e - ref_e) begin
                    ref_next = {VOLT_BITS{1'b1}};
                end else begin
                    ref_next = VOLT_BITS'(ref_e + step_e);
                end
            end else begin
                if (step_e > ref_e) begin
                    ref_next = '0;
                end else begin
                    ref_next = VOLT_BITS'(ref_e - step_e);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gain       <= RST_SLOPE_GAIN;
            r_max_step   <= RST_MAX_STEP;
            r_min_step   <= RST_MIN_STEP;
            r_ref        <= VOLT_BITS'(RST_START_VOLTAGE);
            r_last_volt  <= '0;
            r_last_power <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                case (i_cfg_index)
                    CFG_SLOPE_GAIN: r_gain     <= i_cfg_data;
                    CFG_MAX_STEP:   r_max_step <= i_cfg_data;
                    CFG_MIN_STEP:   r_min_step <= i_cfg_data;
                    CFG_START_VOLTAGE: begin
                        r_ref   <= VOLT_BITS'(i_cfg_data);
                    end
                    default: r_gain <= r_gain;
                endcase
            end
            if (diff_en) begin
                r_last_volt  <= r_volt;
                r_last_power <= power;
            end
            if (apply_en) begin
                r_ref       <= ref_next;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur  <= s_axis_tdata[CUR_BITS-1:0];
            r_volt <= s_axis_tdata[CUR_BITS +: VOLT_BITS];
        end
        if (diff_en) begin
            r_dp_pos <= power > r_last_power;
            r_dp_neg <= power < r_last_power;
            r_dv_pos <= r_volt > r_last_volt;
            r_adp    <= (power > r_last_power) ? power - r_last_power : r_last_power - power;
            r_adv    <= (r_volt > r_last_volt) ? r_volt - r_last_volt : r_last_volt - r_volt;
        end
        if (step_min_en) begin
            r_step <= r_min_step;
        end else if (clamp_en) begin
            r_step <= step_clamped;
        end
        if (apply_en) begin
            r_out_ref <= ref_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_ref);

    assign out_stall = (r_state == S_APPLY) && r_out_valid && !m_axis_tready;

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !s_axis_tready, "ready while busy")
    `ASSERT_IMPLIES(a_done_in_div, i_clk, i_rst_n, div_sts.done, r_state == S_DIV, "stray done")
    `ASSERT_IMPLIES(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE, !div_sts.busy, "busy in idle")
    `ASSERT_NEXT(a_apply_hold, i_clk, i_rst_n, out_stall, r_state == S_APPLY, "beat overwritten")

endmodule

// ===== rtl/core/vsmppt_mul.sv =====
// ----------------------------------------------------------------------------
// vsmppt_mul
// Shared registered multiplier: panel power V*I, then gain*|dP|.
// ----------------------------------------------------------------------------
module vsmppt_mul (
    input  logic                               i_clk,
    input  vsmppt_pkg::t_mul_ctl               i_ctl,
    input  logic [vsmppt_pkg::VOLT_BITS-1:0]   i_volt,
    input  logic [vsmppt_pkg::CUR_BITS-1:0]    i_cur,
    input  logic [vsmppt_pkg::PW-1:0]          i_adp,
    input  logic [vsmppt_pkg::REG_W-1:0]       i_gain,
    output logic [vsmppt_pkg::NW-1:0]          o_prod
);
    import vsmppt_pkg::*;

    logic [PW-1:0] op_a;
    logic [MB-1:0] op_b;
    logic [NW-1:0] r_prod;

    always_comb begin
        if (i_ctl.sel_gain) begin
            op_a = i_adp;
            op_b = MB'(i_gain);
        end else begin
            op_a = PW'(i_volt);
            op_b = MB'(i_cur);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= NW'(op_a) * NW'(op_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/vsmppt_div.sv =====
// ----------------------------------------------------------------------------
// vsmppt_div
// Restoring divider, one quotient bit per cycle over the full numerator.
// ----------------------------------------------------------------------------
module vsmppt_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vsmppt_pkg::t_div_ctl               i_ctl,
    input  logic [vsmppt_pkg::NW-1:0]          i_num,
    input  logic [vsmppt_pkg::VOLT_BITS-1:0]   i_den,
    output vsmppt_pkg::t_div_sts               o_sts,
    output logic [vsmppt_pkg::NW-1:0]          o_quo
);
    import vsmppt_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [NW-1:0]        r_nq;
    logic [VOLT_BITS-1:0] r_rem;
    logic [VOLT_BITS-1:0] r_den;
    logic [VOLT_BITS:0]   trial;
    logic                 qbit;
    logic [VOLT_BITS:0]   diff;

    always_comb begin
        trial = {r_rem, r_nq[NW-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_nq  <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_nq  <= {r_nq[NW-2:0], qbit};
            r_rem <= qbit ? diff[VOLT_BITS-1:0] : trial[VOLT_BITS-1:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_nq;

endmodule

// ===== sim/variable_step_mppt_tracker_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_step_mppt_tracker_unit_test
// Self-checking bench for the variable-step tracker: a directed table of panel
// samples and register writes, then phased random samples under several step
// windows, each result compared against an in-bench model of the tracker or a table value.
// ----------------------------------------------------------------------------
module variable_step_mppt_tracker_unit_test;
    import vsmppt_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int N_PHASES        = 8;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE          = 7 + NW + 8;
    localparam int MAX_REPORTS     = 10;
    localparam logic [63:0] VOLT_MAX = (64'd1 << VOLT_BITS) - 64'd1;
    localparam logic [CIDX_W-1:0] CFG_IDX_SPARE = 4'd4;
    localparam logic [CIDX_W-1:0] CFG_IDX_TOP   = {CIDX_W{1'b1}};

    typedef logic [VOLT_BITS-1:0] t_volt;
    typedef logic [CUR_BITS-1:0]  t_cur;
    typedef logic [PW-1:0]        t_pwr;
    typedef logic [REG_W-1:0]     t_reg;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [CIDX_W-1:0] idx;
        logic [MB-1:0]     a;      // current, or register data
        t_volt             b;      // voltage
        logic              typed;
        t_volt             want;
    } t_plan_row;

    localparam int N_ROWS = 27;

    t_plan_row dir_plan [0:N_ROWS-1] = '{
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd0,     16'd0,     1'b1, 16'd10000},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd100,   16'd1000,  1'b0, 16'd0},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd200,   16'd1000,  1'b0, 16'd0},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd65535, 16'd65535, 1'b0, 16'd0},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd0,     16'd65535, 1'b0, 16'd0},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd0,     16'd0,     1'b0, 16'd0},
        '{ROW_CFG,    CFG_SLOPE_GAIN,    16'd65535, 16'd0,     1'b0, 16'd0},
        '{ROW_CFG,    CFG_MAX_STEP,      16'd65535, 16'd0,     1'b0, 16'd0},
        '{ROW_CFG,    CFG_MIN_STEP,      16'd0,     16'd0,     1'b0, 16'd0},
        '{ROW_CFG,    CFG_START_VOLTAGE, 16'd65535, 16'd0,     1'b0, 16'd0},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd65535, 16'd1,     1'b1, 16'd65535},
        '{ROW_CFG,    CFG_START_VOLTAGE, 16'd0,     16'd0,     1'b0, 16'd0},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd1,     16'd65535, 1'b1, 16'd0},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd65535, 16'd100,   1'b1, 16'd0},
        '{ROW_CFG,    CFG_SLOPE_GAIN,    16'd0,     16'd0,     1'b0, 16'd0},
        '{ROW_CFG,    CFG_MIN_STEP,      16'd300,   16'd0,     1'b0, 16'd0},
        '{ROW_CFG,    CFG_MAX_STEP,      16'd5,     16'd0,     1'b0, 16'd0},
        '{ROW_CFG,    CFG_START_VOLTAGE, 16'd1000,  16'd0,     1'b0, 16'd0},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd50,    16'd200,   1'b0, 16'd0},
        '{ROW_CFG,    CFG_IDX_TOP,       16'd65535, 16'd0,     1'b0, 16'd0},
        '{ROW_CFG,    CFG_IDX_SPARE,     16'd0,     16'd0,     1'b0, 16'd0},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd50,    16'd200,   1'b0, 16'd0},
        '{ROW_SAMPLE, CFG_SLOPE_GAIN,    16'd60,    16'd200,   1'b0, 16'd0},
        '{ROW_CFG,    CFG_SLOPE_GAIN,    RST_SLOPE_GAIN,    16'd0, 1'b0, 16'd0},
        '{ROW_CFG,    CFG_MAX_STEP,      RST_MAX_STEP,      16'd0, 1'b0, 16'd0},
        '{ROW_CFG,    CFG_MIN_STEP,      RST_MIN_STEP,      16'd0, 1'b0, 16'd0},
        '{ROW_CFG,    CFG_START_VOLTAGE, RST_START_VOLTAGE, 16'd0, 1'b0, 16'd0}
    };

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index   = '0;
    logic [REG_W-1:0]  i_cfg_data    = '0;

    always #5 i_clk = ~i_clk;

    variable_step_mppt_tracker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // tracker model: register copies and last-sample state
    t_reg  gain_r    = RST_SLOPE_GAIN;
    t_reg  max_r     = RST_MAX_STEP;
    t_reg  min_r     = RST_MIN_STEP;
    t_volt prev_volt = '0;
    t_pwr  prev_pwr  = '0;
    t_volt ref_now   = t_volt'(RST_START_VOLTAGE);

    t_volt ref_expect_q [$];
    int    mismatches = 0;

    bit idle_on       = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int stall_left    = 0;

    function automatic void apply_register(logic [CIDX_W-1:0] idx, t_reg data);
        case (idx)
            CFG_SLOPE_GAIN:    gain_r = data;
            CFG_MAX_STEP:      max_r  = data;
            CFG_MIN_STEP:      min_r  = data;
            CFG_START_VOLTAGE: ref_now = t_volt'(data);
            default: ;
        endcase
    endfunction

    function automatic t_volt track_reference(t_cur cur, t_volt volt);
        logic [63:0] pwr, adp, adv, stp, lvl;
        logic        dp_pos, dp_neg, dv_pos;
        pwr    = 64'(volt) * 64'(cur);
        dp_pos = pwr > 64'(prev_pwr);
        dp_neg = pwr < 64'(prev_pwr);
        dv_pos = volt > prev_volt;
        adp    = dp_pos ? pwr - 64'(prev_pwr) : 64'(prev_pwr) - pwr;
        adv    = dv_pos ? 64'(volt) - 64'(prev_volt) : 64'(prev_volt) - 64'(volt);
        if (adv != 64'd0) begin
            stp = ((adp * 64'(gain_r)) / adv) >> SCALE_SHIFT;
            if (stp > 64'(max_r)) stp = 64'(max_r);
            if (stp < 64'(min_r)) stp = 64'(min_r);
        end else begin
            stp = 64'(min_r);
        end
        lvl = 64'(ref_now);
        if (dp_pos || dp_neg) begin
            if (dp_pos == dv_pos) lvl = (stp > VOLT_MAX - lvl) ? VOLT_MAX : lvl + stp;
            else                  lvl = (stp > lvl) ? 64'd0 : lvl - stp;
        end
        ref_now   = t_volt'(lvl);
        prev_volt = volt;
        prev_pwr  = t_pwr'(pwr);
        return ref_now;
    endfunction

    function automatic int clip(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    task automatic note_mismatch(string what, t_volt want, logic [OUT_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, want, got);
    endtask

    // receiver: random stall bursts, plus one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served   <= hold_requests;
            stall_left    <= LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : score_refs
        t_volt want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ref_expect_q.size() == 0) begin
                note_mismatch("result beat with no sample pending", '0, m_axis_tdata);
            end else begin
                want = ref_expect_q.pop_front();
                if (m_axis_tdata !== OUT_W'(want))
                    note_mismatch("voltage_reference", want, m_axis_tdata);
            end
        end
    end

    task automatic send_sample(t_cur cur, t_volt volt, logic typed, t_volt want);
        t_volt pred;
        i_cfg_valid <= 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({volt, cur});
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        pred = track_reference(cur, volt);
        ref_expect_q.push_back(typed ? want : pred);
    endtask

    // leaves valid high so writes can go back to back
    task automatic write_register(logic [CIDX_W-1:0] idx, t_reg data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        apply_register(idx, data);
    endtask

    task automatic drain_refs();
        s_axis_tvalid <= 1'b0;
        while (ref_expect_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin : run
        int    mode;
        t_cur  cur;
        t_volt volt;
        t_reg  g, mx, mn, sv;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_plan[r]) begin
            if (dir_plan[r].kind == ROW_CFG) begin
                drain_refs();
                write_register(dir_plan[r].idx, t_reg'(dir_plan[r].a));
            end else begin
                send_sample(t_cur'(dir_plan[r].a), dir_plan[r].b, dir_plan[r].typed,
                            dir_plan[r].want);
            end
        end

        cur  = t_cur'(dir_plan[22].a);
        volt = dir_plan[22].b;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_refs();
            if (ph == N_PHASES - 1) idle_on <= 1'b0;
            g  = t_reg'($urandom_range(0, 65535));
            mx = t_reg'($urandom_range(0, 65535));
            mn = t_reg'($urandom_range(0, 65535));
            sv = t_reg'($urandom_range(0, 65535));
            case (ph)
                0: begin
                    g = RST_SLOPE_GAIN; mx = RST_MAX_STEP;
                    mn = RST_MIN_STEP;  sv = RST_START_VOLTAGE;
                end
                1: begin g = '1; mn = t_reg'($urandom_range(0, 255)); end
                2: begin g = '0; mn = t_reg'($urandom_range(0, 100)); sv = '1; end
                3: begin g = t_reg'($urandom_range(0, 4095)); mx = '0; mn = '0; end
                4: begin mn = '1; sv = '0; end
                6: begin g = t_reg'($urandom_range(0, 1023)); mx = '1; mn = '0; end
                7: begin
                    g  = t_reg'($urandom_range(1, 2000));
                    mx = t_reg'($urandom_range(100, 1000));
                    mn = t_reg'($urandom_range(0, 20));
                end
                default: ;
            endcase
            write_register(CFG_SLOPE_GAIN, g);
            write_register(CFG_MAX_STEP, mx);
            write_register(CFG_MIN_STEP, mn);
            write_register(CFG_START_VOLTAGE, sv);
            if ($urandom_range(0, 1) == 1)
                write_register(CIDX_W'($urandom_range(CFG_IDX_SPARE, CFG_IDX_TOP)),
                               t_reg'($urandom_range(0, 65535)));
            if (ph == 3) hold_requests <= hold_requests + 1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 5 && n == ITEMS_PER_PHASE / 2) drain_refs();
                mode = $urandom_range(0, 9);
                if (mode <= 2) begin
                    cur  = t_cur'($urandom_range(0, 65535));
                    volt = t_volt'($urandom_range(0, 65535));
                end else if (mode <= 7) begin
                    // perturb around the last operating point
                    cur  = t_cur'(clip(int'(cur) + $urandom_range(0, 512) - 256, 65535));
                    volt = t_volt'(clip(int'(volt) + $urandom_range(0, 128) - 64, 65535));
                end else if (mode == 8) begin
                    cur  = t_cur'(clip(int'(cur) + $urandom_range(0, 64) - 32, 65535));
                end
                send_sample(cur, volt, 1'b0, '0);
            end
        end

        drain_refs();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && ref_expect_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/vsmppt_pkg.sv
rtl/core/vsmppt_mul.sv
rtl/core/vsmppt_div.sv
rtl/core/variable_step_mppt_tracker_unit.sv
sim/variable_step_mppt_tracker_unit_test.sv
